// ===== hdl/hlfs_pkg.sv =====
// Shared types and constants for the header/length frame sync block.
// Used by hlfs_parser, hlfs_evq and header_length_frame_sync.
`default_nettype none

package hlfs_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [7:0] TYPE_C0   = 8'hC0;
  localparam logic [7:0] TYPE_C7   = 8'hC7;
  localparam logic [7:0] TYPE_CB   = 8'hCB;
  localparam logic [7:0] TYPE_CC   = 8'hCC;

  localparam int unsigned EVQ_DEPTH = 4;
  localparam int unsigned EVQ_AW    = $clog2(EVQ_DEPTH);

  localparam logic [1:0] BEAT_SYNC = 2'd0;
  localparam logic [1:0] BEAT_TYPE = 2'd1;
  localparam logic [1:0] BEAT_LEN  = 2'd2;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_TYPE = 2'd1,
    PH_LEN  = 2'd2,
    PH_BODY = 2'd3
  } phase_e;

  // One queued event: a whole header (three output words) or one body word.
  typedef struct packed {
    logic       is_hdr;
    logic [7:0] data;
    logic [7:0] hdr_type;
    logic       last;
    logic [8:0] frame_len;
  } event_t;

  function automatic logic valid_type(input logic [7:0] b);
    return (b == TYPE_C0) || (b == TYPE_C7) || (b == TYPE_CB) || (b == TYPE_CC);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/hlfs_parser.sv =====
// Header/length parser: one word per cycle (take_i high) updates sync state.
// Produces one event per header or body word. Depends on hlfs_pkg.
`default_nettype none

module hlfs_parser (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            take_i,
  input  wire logic [7:0]      rx_byte_i,
  output hlfs_pkg::event_t     ev_o,
  output logic                 ev_valid_o
);
  import hlfs_pkg::*;

  phase_e     phase_q, phase_d;
  logic [7:0] type_q, type_d;
  logic [7:0] rem_q, rem_d;
  logic [8:0] len_q, len_d;
  logic [8:0] new_len;

  assign new_len = {1'b0, rx_byte_i} + 9'd2;

  always_comb begin
    phase_d = phase_q;
    if (take_i) begin
      unique case (phase_q)
        PH_HUNT: begin
          if (rx_byte_i == SYNC_BYTE) phase_d = PH_TYPE;
        end
        PH_TYPE: begin
          if (valid_type(rx_byte_i)) begin
            phase_d = PH_LEN;
          end else if (rx_byte_i == SYNC_BYTE) begin
            phase_d = PH_TYPE;
          end else begin
            phase_d = PH_HUNT;
          end
        end
        PH_LEN: begin
          if (rx_byte_i == 8'd0 || rx_byte_i == 8'd1) begin
            phase_d = PH_HUNT;
          end else begin
            phase_d = PH_BODY;
          end
        end
        PH_BODY: begin
          if (rem_q <= 8'd1) phase_d = PH_HUNT;
        end
        default: phase_d = PH_HUNT;
      endcase
    end
  end

  always_comb begin
    type_d     = type_q;
    rem_d      = rem_q;
    len_d      = len_q;
    ev_valid_o = 1'b0;
    ev_o       = '{is_hdr: 1'b0, data: rx_byte_i, hdr_type: type_q,
                   last: 1'b0, frame_len: len_q};
    unique case (phase_q)
      PH_TYPE: begin
        if (take_i && valid_type(rx_byte_i)) type_d = rx_byte_i;
      end
      PH_LEN: begin
        if (rx_byte_i != 8'd0) begin
          ev_valid_o   = 1'b1;
          ev_o.is_hdr  = 1'b1;
          ev_o.last    = (rx_byte_i == 8'd1);
          ev_o.frame_len = new_len;
          if (take_i) begin
            len_d = new_len;
            rem_d = rx_byte_i - 8'd1;
          end
        end
      end
      PH_BODY: begin
        ev_valid_o = 1'b1;
        ev_o.last  = (rem_q <= 8'd1);
        if (take_i) rem_d = (rem_q <= 8'd1) ? 8'd0 : rem_q - 8'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      type_q  <= 8'd0;
      rem_q   <= 8'd0;
      len_q   <= 9'd0;
    end else begin
      phase_q <= phase_d;
      type_q  <= type_d;
      rem_q   <= rem_d;
      len_q   <= len_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hlfs_evq.sv =====
// Event queue and serializer: stores parser events and sends them one word a cycle
// while frame_stall_i is low; a header leaves as three words. Depends on hlfs_pkg.
`default_nettype none

module hlfs_evq (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire hlfs_pkg::event_t ev_i,
  output logic                  full_o,
  output logic                  frame_valid_o,
  input  wire logic             frame_stall_i,
  output logic [7:0]            frame_byte_o,
  output logic                  first_of_frame_o,
  output logic                  last_of_frame_o,
  output logic [8:0]            frame_length_o
);
  import hlfs_pkg::*;

  event_t              mem_q [EVQ_DEPTH];
  logic [EVQ_AW-1:0]   wr_q, rd_q;
  logic [EVQ_AW:0]     cnt_q, cnt_d;
  logic [1:0]          beat_q, beat_d;
  event_t              head;
  logic                word_out, pop;

  assign head          = mem_q[rd_q];
  assign full_o        = (cnt_q == (EVQ_AW+1)'(EVQ_DEPTH));
  assign frame_valid_o = (cnt_q != '0);
  assign word_out      = frame_valid_o && !frame_stall_i;
  assign pop           = word_out && (!head.is_hdr || beat_q == BEAT_LEN);
  assign frame_length_o = head.frame_len;

  always_comb begin
    frame_byte_o     = head.data;
    first_of_frame_o = 1'b0;
    last_of_frame_o  = head.last;
    if (head.is_hdr) begin
      case (beat_q)
        BEAT_SYNC: begin
          frame_byte_o     = SYNC_BYTE;
          first_of_frame_o = 1'b1;
          last_of_frame_o  = 1'b0;
        end
        BEAT_TYPE: begin
          frame_byte_o    = head.hdr_type;
          last_of_frame_o = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    beat_d = beat_q;
    if (pop) begin
      beat_d = BEAT_SYNC;
    end else if (word_out) begin
      beat_d = beat_q + 2'd1;
    end
    cnt_d = cnt_q + (EVQ_AW+1)'(push_i) - (EVQ_AW+1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= ev_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      cnt_q  <= '0;
      beat_q <= BEAT_SYNC;
    end else begin
      if (push_i) wr_q <= wr_q + EVQ_AW'(1);
      if (pop) rd_q <= rd_q + EVQ_AW'(1);
      cnt_q  <= cnt_d;
      beat_q <= beat_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/header_length_frame_sync.sv =====
// Header/length frame sync: finds 0xFF/type/length frames in a word stream.
// Each taken body word, and each header at its nonzero length word, is queued;
// a header leaves the queue as three words: sync, type and length.
// Throughput: one input word per cycle; the four-entry event queue stalls input
// only when full. Output: one word per cycle unless stalled. Reset clears state
// and queue. Depends on hlfs_pkg, hlfs_parser and hlfs_evq.
`default_nettype none

module header_length_frame_sync (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       rx_valid_i,
  output logic            rx_stall_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            frame_valid_o,
  input  wire logic       frame_stall_i,
  output logic [7:0]      frame_byte_o,
  output logic            first_of_frame_o,
  output logic            last_of_frame_o,
  output logic [8:0]      frame_length_o
);
  import hlfs_pkg::*;

  event_t ev;
  logic   ev_valid, full, take;

  assign rx_stall_o = full;
  assign take       = rx_valid_i && !full;

  hlfs_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .rx_byte_i  (rx_byte_i),
    .ev_o       (ev),
    .ev_valid_o (ev_valid)
  );

  hlfs_evq u_evq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (take && ev_valid),
    .ev_i             (ev),
    .full_o           (full),
    .frame_valid_o    (frame_valid_o),
    .frame_stall_i    (frame_stall_i),
    .frame_byte_o     (frame_byte_o),
    .first_of_frame_o (first_of_frame_o),
    .last_of_frame_o  (last_of_frame_o),
    .frame_length_o   (frame_length_o)
  );

  a_first_is_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_valid_o && first_of_frame_o |-> frame_byte_o == SYNC_BYTE)
    else $error("first word of a frame is not the sync word");

  a_first_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_valid_o |-> !(first_of_frame_o && last_of_frame_o))
    else $error("a word is marked both first and last");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_valid_o |-> frame_length_o >= 9'd3 && frame_length_o <= 9'd257)
    else $error("frame length out of range");

  a_first_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_valid_o && !frame_stall_i && first_of_frame_o |=>
      frame_valid_o && !first_of_frame_o && !last_of_frame_o)
    else $error("header words not sent together");

endmodule

`default_nettype wire

// ===== test/header_length_frame_sync_tb.sv =====
// Self-checking testbench for header_length_frame_sync: drives byte streams, predicts the
// frame words from its own model of the sync logic and compares every output word in order.
// Depends on hlfs_pkg and the header_length_frame_sync RTL.
`timescale 1ns / 1ps

module header_length_frame_sync_tb;
  import hlfs_pkg::*;

  localparam int IdleLimit = 2000;
  localparam int ReportMax = 10;
  localparam int TailCycles = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic [8:0] len;
  } frame_word_t;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       rx_valid_i = 1'b0;
  logic       rx_stall_o;
  logic [7:0] rx_byte_i = 8'h00;
  logic       frame_valid_o;
  logic       frame_stall_i = 1'b0;
  logic [7:0] frame_byte_o;
  logic       first_of_frame_o;
  logic       last_of_frame_o;
  logic [8:0] frame_length_o;

  header_length_frame_sync dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rx_valid_i      (rx_valid_i),
    .rx_stall_o      (rx_stall_o),
    .rx_byte_i       (rx_byte_i),
    .frame_valid_o   (frame_valid_o),
    .frame_stall_i   (frame_stall_i),
    .frame_byte_o    (frame_byte_o),
    .first_of_frame_o(first_of_frame_o),
    .last_of_frame_o (last_of_frame_o),
    .frame_length_o  (frame_length_o)
  );

  frame_word_t frame_words_q[$];
  phase_e      hunt_phase = PH_HUNT;
  logic [7:0]  latched_type = 8'h00;
  logic [7:0]  body_left = 8'h00;
  logic [8:0]  frame_total = 9'd0;

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int unsigned bytes_sent = 0;
  int unsigned words_checked = 0;
  int unsigned frames_done = 0;
  int unsigned longest_frame = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void push_frame_word(input logic [7:0] b, input logic first,
                                          input logic last);
    frame_words_q.push_back('{b, first, last, frame_total});
  endfunction

  function automatic void track_sync_byte(input logic [7:0] b);
    case (hunt_phase)
      PH_HUNT: begin
        if (b == SYNC_BYTE) hunt_phase = PH_TYPE;
      end
      PH_TYPE: begin
        if (b inside {TYPE_C0, TYPE_C7, TYPE_CB, TYPE_CC}) begin
          latched_type = b;
          hunt_phase = PH_LEN;
        end else if (b != SYNC_BYTE) begin
          hunt_phase = PH_HUNT;
        end
      end
      PH_LEN: begin
        if (b == 8'h00) begin
          hunt_phase = PH_HUNT;
        end else begin
          frame_total = 9'(b) + 9'd2;
          push_frame_word(SYNC_BYTE, 1'b1, 1'b0);
          push_frame_word(latched_type, 1'b0, 1'b0);
          if (b == 8'h01) begin
            push_frame_word(b, 1'b0, 1'b1);
            body_left = 8'h00;
            hunt_phase = PH_HUNT;
          end else begin
            push_frame_word(b, 1'b0, 1'b0);
            body_left = b - 8'h01;
            hunt_phase = PH_BODY;
          end
        end
      end
      default: begin
        if (body_left <= 8'h01) begin
          push_frame_word(b, 1'b0, 1'b1);
          body_left = 8'h00;
          hunt_phase = PH_HUNT;
        end else begin
          push_frame_word(b, 1'b0, 1'b0);
          body_left = body_left - 8'h01;
        end
      end
    endcase
  endfunction

  always @(posedge clk_i) begin
    frame_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin : check_words
    frame_word_t got;
    frame_word_t want;
    logic        progress;
    if (rst_ni) begin
      progress = 1'b0;
      if (frame_valid_o && !frame_stall_i) begin
        progress = 1'b1;
        got = '{frame_byte_o, first_of_frame_o, last_of_frame_o, frame_length_o};
        words_checked++;
        if (last_of_frame_o && frame_length_o > longest_frame)
          longest_frame = 32'(frame_length_o);
        if (last_of_frame_o) frames_done++;
        if (frame_words_q.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportMax)
            $display("Unexpected word: byte %h first %b last %b length %0d",
                     got.data, got.first, got.last, got.len);
        end else begin
          want = frame_words_q.pop_front();
          if (got.data !== want.data || got.first !== want.first ||
              got.last !== want.last || got.len !== want.len) begin
            mismatches++;
            if (mismatches <= ReportMax)
              $display("Word %0d: expected %h/%b/%b/%0d, got %h/%b/%b/%0d",
                       words_checked, want.data, want.first, want.last, want.len,
                       got.data, got.first, got.last, got.len);
          end
        end
      end
      if (rx_valid_i && !rx_stall_o) begin
        progress = 1'b1;
        track_sync_byte(rx_byte_i);
      end
      quiet_cycles = progress ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
        $display("Timeout: no word moved for %0d cycles", IdleLimit);
        $display("header_length_frame_sync_tb: FAIL");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      rx_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (rx_stall_o);
    bytes_sent++;
  endtask

  task automatic drain_frames();
    rx_valid_i <= 1'b0;
    do @(posedge clk_i); while (frame_words_q.size() != 0);
  endtask

  function automatic logic [7:0] random_type();
    case ($urandom_range(3))
      0: return TYPE_C0;
      1: return TYPE_C7;
      2: return TYPE_CB;
      default: return TYPE_CC;
    endcase
  endfunction

  function automatic logic [7:0] random_bad_type();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (b inside {SYNC_BYTE, TYPE_C0, TYPE_C7, TYPE_CB, TYPE_CC})
      b = 8'($urandom_range(255));
    return b;
  endfunction

  function automatic logic [7:0] random_body();
    if ($urandom_range(7) == 0) return SYNC_BYTE;
    return 8'($urandom_range(255));
  endfunction

  task automatic test_header_types();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_byte(SYNC_BYTE);
    send_byte(TYPE_C0);
    send_byte(8'h01);
    send_byte(SYNC_BYTE);
    send_byte(TYPE_C7);
    send_byte(8'h02);
    send_byte(8'hAA);
    send_byte(SYNC_BYTE);
    send_byte(TYPE_CB);
    send_byte(8'h01);
    send_byte(SYNC_BYTE);
    send_byte(TYPE_CC);
    send_byte(8'h01);
    drain_frames();
  endtask

  task automatic test_special_cases();
    // Repeated sync before the type, then a sync value carried as frame data.
    send_byte(SYNC_BYTE);
    send_byte(SYNC_BYTE);
    send_byte(TYPE_C0);
    send_byte(8'h02);
    send_byte(SYNC_BYTE);
    // A near-miss type drops back to hunting.
    send_byte(SYNC_BYTE);
    send_byte(8'hC1);
    // Zero in the hunt state, then a zero length byte.
    send_byte(8'h00);
    send_byte(SYNC_BYTE);
    send_byte(TYPE_C7);
    send_byte(8'h00);
    drain_frames();
  endtask

  task automatic test_longest_frame();
    send_idle_pct = 31;
    recv_stall_pct = 31;
    send_byte(SYNC_BYTE);
    send_byte(TYPE_CC);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(SYNC_BYTE);
    repeat (252) send_byte(8'($urandom_range(255)));
    drain_frames();
  endtask

  task automatic send_random_sequence();
    int unsigned len;
    if ($urandom_range(99) < 75) begin
      send_byte(SYNC_BYTE);
      if ($urandom_range(9) == 0) send_byte(SYNC_BYTE);
      send_byte(random_type());
      len = ($urandom_range(39) == 0) ? $urandom_range(64, 17) : $urandom_range(16, 1);
      send_byte(8'(len));
      repeat (len - 1) send_byte(random_body());
    end else begin
      case ($urandom_range(3))
        0: repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
        1: begin
          send_byte(SYNC_BYTE);
          send_byte(random_bad_type());
        end
        2: begin
          send_byte(SYNC_BYTE);
          send_byte(random_type());
          send_byte(8'h00);
        end
        default: begin
          send_byte(SYNC_BYTE);
          send_byte(8'($urandom_range(255)));
        end
      endcase
    end
  endtask

  task automatic test_mixed_traffic(input int unsigned count, input int idle_pct,
                                    input int stall_pct);
    int unsigned start;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    start = bytes_sent;
    while (bytes_sent - start < count) begin
      send_random_sequence();
      if ($urandom_range(29) == 0) drain_frames();
    end
    drain_frames();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_header_types();
    test_special_cases();
    test_mixed_traffic(6, 0, 0);
    test_mixed_traffic(6, 69, 0);
    test_mixed_traffic(6, 0, 69);
    test_mixed_traffic(6, 31, 31);
    test_longest_frame();
    drain_frames();
    repeat (TailCycles) @(posedge clk_i);
    $display("Sent %0d bytes under four idle/stall mixes; checked %0d words in %0d frames.",
             bytes_sent, words_checked, frames_done);
    $display("Longest frame seen: %0d bytes; mismatches: %0d.", longest_frame, mismatches);
    if (mismatches == 0 && frame_words_q.size() == 0) begin
      $display("header_length_frame_sync_tb: PASS");
    end else begin
      $display("header_length_frame_sync_tb: FAIL");
    end
    $finish;
  end

endmodule
